### design/sapb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapb_pkg
// Types, constants and the divide-by-255 helper for the straight alpha
// pixel blender.
// ----------------------------------------------------------------------------
package sapb_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_MULTIPLY = 2'd1,
    MODE_SCREEN   = 2'd2,
    MODE_ADD      = 2'd3
  } blend_mode_e;

  typedef enum logic {
    CFG_BLEND_MODE    = 1'b0,
    CFG_LAYER_OPACITY = 1'b1
  } cfg_index_e;

  localparam int unsigned DivSteps = 8;
  localparam logic [15:0] Unit2    = 16'd65025;
  localparam logic [15:0] FaintMax = 16'd65;
  localparam logic [15:0] HalfUnit = 16'd32512;
  localparam logic [15:0] Recip255 = 16'd32896;
  localparam logic [7:0]  Full     = 8'd255;
  localparam logic [7:0]  Half     = 8'd127;

  typedef struct packed {
    logic [3:0][7:0] bot;
    logic [2:0][7:0] top;
    blend_mode_e     mode;
    logic [15:0]     p;
  } s1_t;

  typedef struct packed {
    logic [3:0][7:0]  bot;
    logic [2:0][7:0]  top;
    blend_mode_e      mode;
    logic [15:0]      p;
    logic [2:0][15:0] y;
    logic [15:0]      yp;
    logic [2:0][15:0] cbba;
    logic             faint;
  } s2_t;

  typedef struct packed {
    logic [3:0][7:0]  bot;
    blend_mode_e      mode;
    logic [2:0][7:0]  t;
    logic [15:0]      peff;
    logic [2:0][15:0] cbba;
    logic             bypass;
  } s3_t;

  typedef struct packed {
    logic [3:0][7:0]  bot;
    blend_mode_e      mode;
    logic             bypass;
    logic [2:0][32:0] n;
    logic [24:0]      d;
    logic [2:0][23:0] az;
    logic [23:0]      ra;
  } s4_t;

  typedef struct packed {
    logic [3:0][7:0]  bot;
    blend_mode_e      mode;
    logic             bypass;
    logic [2:0][32:0] rem;
    logic [24:0]      d;
    logic [2:0][7:0]  q;
    logic [2:0][16:0] aq;
    logic [16:0]      al;
  } div_t;

  // floor(z / 255) for z below 255 * 2**16
  function automatic logic [18:0] div255(input logic [25:0] z);
    logic [41:0] prod;
    logic [18:0] q0;
    logic [26:0] back;
    logic [26:0] rem;
    prod = 42'(z) * 42'(Recip255);
    q0   = prod[41:23];
    back = {q0, 8'd0} - {8'd0, q0};
    rem  = {1'b0, z} - back;
    if (rem >= 27'd255) begin
      q0 = q0 + 19'd1;
    end
    return q0;
  endfunction

endpackage

### design/straight_alpha_pixel_blender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// straight_alpha_pixel_blender
// RGBA8888 straight alpha blender: normal, multiply, screen and additive
// modes with layer opacity, pipelined with a bit-per-stage divider.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   bottom_*_i, top_*_i
// out      output     out_valid_o / out_stall_i out_*_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one item per cycle while the output is not stalled; 4 arithmetic stages, 8 divider
// stages of one quotient bit each, one output register
// reset clears all valid bits and loads mode normal, opacity 255
// a stalled output holds the whole pipeline; the pipeline advances, bubbles
// included, whenever the output register is empty or drains
// ----------------------------------------------------------------------------
module straight_alpha_pixel_blender (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] bottom_red_i,
  input  logic [7:0] bottom_green_i,
  input  logic [7:0] bottom_blue_i,
  input  logic [7:0] bottom_alpha_i,
  input  logic [7:0] top_red_i,
  input  logic [7:0] top_green_i,
  input  logic [7:0] top_blue_i,
  input  logic [7:0] top_alpha_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  sapb_pkg::blend_mode_e mode_q;
  logic [7:0]            opacity_q;

  logic en;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic [sapb_pkg::DivSteps-1:0] div_v_q;

  sapb_pkg::s1_t s1_d, s1_q;
  sapb_pkg::s2_t s2_d, s2_q;
  sapb_pkg::s3_t s3_d, s3_q;
  sapb_pkg::s4_t s4_d, s4_q;
  sapb_pkg::div_t div_in;
  sapb_pkg::div_t div_d [sapb_pkg::DivSteps];
  sapb_pkg::div_t div_q [sapb_pkg::DivSteps];
  logic [3:0][7:0] out_d, out_q;

  assign en          = !(out_v_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= sapb_pkg::MODE_NORMAL;
      opacity_q <= sapb_pkg::Full;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (sapb_pkg::cfg_index_e'(cfg_index_i))
        sapb_pkg::CFG_BLEND_MODE:    mode_q    <= sapb_pkg::blend_mode_e'(cfg_data_i[1:0]);
        sapb_pkg::CFG_LAYER_OPACITY: opacity_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: scaled top alpha
  always_comb begin
    s1_d.bot  = {bottom_alpha_i, bottom_blue_i, bottom_green_i, bottom_red_i};
    s1_d.top  = {top_blue_i, top_green_i, top_red_i};
    s1_d.mode = mode_q;
    s1_d.p    = 16'(top_alpha_i) * 16'(opacity_q);
  end

  // stage 2: products for the intermediate colour and the bottom weight
  always_comb begin
    logic [15:0] sprod;
    s2_d.bot   = s1_q.bot;
    s2_d.top   = s1_q.top;
    s2_d.mode  = s1_q.mode;
    s2_d.p     = s1_q.p;
    s2_d.yp    = s1_q.p + 16'(sapb_pkg::Half);
    s2_d.faint = s1_q.p <= sapb_pkg::FaintMax;
    for (int c = 0; c < 3; c++) begin
      sprod = 16'(sapb_pkg::Full - s1_q.bot[c]) * 16'(sapb_pkg::Full - s1_q.top[c]);
      if (s1_q.mode == sapb_pkg::MODE_MULTIPLY) begin
        s2_d.y[c] = 16'(s1_q.bot[c]) * 16'(s1_q.top[c]) + 16'(sapb_pkg::Half);
      end else begin
        s2_d.y[c] = sapb_pkg::Unit2 - sprod + 16'(sapb_pkg::Half);
      end
      s2_d.cbba[c] = 16'(s1_q.bot[c]) * 16'(s1_q.bot[3]);
    end
  end

  // stage 3: intermediate colour, effective top alpha, pass-through decision
  always_comb begin
    logic [7:0] ia;
    logic [18:0] qa;
    logic [18:0] qc;
    logic is_mid;
    is_mid = (s2_q.mode == sapb_pkg::MODE_MULTIPLY) || (s2_q.mode == sapb_pkg::MODE_SCREEN);
    qa     = sapb_pkg::div255(26'(s2_q.yp));
    ia     = qa[7:0];
    s3_d.bot  = s2_q.bot;
    s3_d.mode = s2_q.mode;
    s3_d.cbba = s2_q.cbba;
    for (int c = 0; c < 3; c++) begin
      qc = sapb_pkg::div255(26'(s2_q.y[c]));
      s3_d.t[c] = is_mid ? qc[7:0] : s2_q.top[c];
    end
    s3_d.peff   = is_mid ? ({ia, 8'd0} - {8'd0, ia}) : s2_q.p;
    s3_d.bypass = s2_q.faint || (is_mid && ia == 8'd0);
  end

  // stage 4: result alpha numerator and channel numerators
  always_comb begin
    logic [15:0] inv;
    logic [23:0] r;
    logic [23:0] tp;
    logic [31:0] num;
    inv = sapb_pkg::Unit2 - s3_q.peff;
    r   = ({8'd0, s3_q.peff} << 8) - 24'(s3_q.peff) + 24'(s3_q.bot[3]) * 24'(inv);
    s4_d.bot    = s3_q.bot;
    s4_d.mode   = s3_q.mode;
    s4_d.bypass = s3_q.bypass;
    s4_d.d      = {r, 1'b0};
    s4_d.ra     = r + 24'(sapb_pkg::HalfUnit);
    for (int c = 0; c < 3; c++) begin
      tp  = 24'(s3_q.t[c]) * 24'(s3_q.peff);
      num = {tp, 8'd0} - 32'(tp) + 32'(s3_q.cbba[c]) * 32'(inv);
      s4_d.n[c]  = {num, 1'b0} + 33'(r);
      s4_d.az[c] = tp + 24'(sapb_pkg::HalfUnit);
    end
  end

  // divider stages, one quotient bit each; additive and alpha divide by 255 twice
  always_comb begin
    logic [18:0] tmp;
    sapb_pkg::div_t cur;
    logic [32:0] dsh;
    div_in.bot    = s4_q.bot;
    div_in.mode   = s4_q.mode;
    div_in.bypass = s4_q.bypass;
    div_in.rem    = s4_q.n;
    div_in.d      = s4_q.d;
    div_in.q      = '0;
    for (int c = 0; c < 3; c++) begin
      tmp = sapb_pkg::div255(26'(s4_q.az[c]));
      div_in.aq[c] = tmp[16:0];
    end
    tmp       = sapb_pkg::div255(26'(s4_q.ra));
    div_in.al = tmp[16:0];
    for (int k = 0; k < sapb_pkg::DivSteps; k++) begin
      cur = (k == 0) ? div_in : div_q[(k == 0) ? 0 : k - 1];
      dsh = 33'(cur.d) << (sapb_pkg::DivSteps - 1 - k);
      for (int c = 0; c < 3; c++) begin
        if (cur.rem[c] >= dsh) begin
          cur.rem[c] = cur.rem[c] - dsh;
          cur.q[c][sapb_pkg::DivSteps-1-k] = 1'b1;
        end
        if (k == 1) begin
          tmp = sapb_pkg::div255(26'(cur.aq[c]));
          cur.aq[c] = tmp[16:0];
        end
      end
      if (k == 1) begin
        tmp    = sapb_pkg::div255(26'(cur.al));
        cur.al = tmp[16:0];
      end
      div_d[k] = cur;
    end
  end

  // output selection
  always_comb begin
    sapb_pkg::div_t last;
    logic [8:0] sum;
    last = div_q[sapb_pkg::DivSteps-1];
    for (int c = 0; c < 3; c++) begin
      sum = {1'b0, last.bot[c]} + {1'b0, last.aq[c][7:0]};
      if (last.bypass) begin
        out_d[c] = last.bot[c];
      end else if (last.mode == sapb_pkg::MODE_ADD) begin
        out_d[c] = sum[8] ? sapb_pkg::Full : sum[7:0];
      end else begin
        out_d[c] = last.q[c];
      end
    end
    out_d[3] = last.bypass ? last.bot[3] : last.al[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      div_v_q <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      div_v_q <= {div_v_q[sapb_pkg::DivSteps-2:0], s4_v_q};
      out_v_q <= div_v_q[sapb_pkg::DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s4_d;
      div_q <= div_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];
  assign out_alpha_o = out_q[3];

`ifndef NO_ASSERTIONS
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_v_q)
    else $error("accepted item missing from stage 1");

  a_divisor_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_v_q[0] && !div_q[0].bypass) |-> (div_q[0].d != '0))
    else $error("zero divisor on a blended item");

  a_rem_red : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_v_q[sapb_pkg::DivSteps-1] && !div_q[sapb_pkg::DivSteps-1].bypass) |->
    (div_q[sapb_pkg::DivSteps-1].rem[0] < 33'(div_q[sapb_pkg::DivSteps-1].d)))
    else $error("red remainder not below divisor");

  a_rem_blue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_v_q[sapb_pkg::DivSteps-1] && !div_q[sapb_pkg::DivSteps-1].bypass) |->
    (div_q[sapb_pkg::DivSteps-1].rem[2] < 33'(div_q[sapb_pkg::DivSteps-1].d)))
    else $error("blue remainder not below divisor");
`endif

endmodule
